@@ design/si_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_pkg : shared types and constants for the spectral inharmonicity core
// Register indexes and the item type passed from front end to back end.
// ----------------------------------------------------------------------------
package si_pkg;

	localparam int FreqW = 44;
	localparam int AmpW  = 24;
	localparam int WsumW = 48;
	localparam int AsumW = 31;
	localparam int QW    = 17;

	localparam logic REG_MAX_PEAKS = 1'b0;
	localparam logic REG_BIN_FREQ  = 1'b1;

	localparam logic [QW-1:0] Q_ONE = 17'h10000;

	// work item from the front end: one peak to accumulate and/or a frame end
	typedef struct packed {
		logic             use_peak;
		logic [FreqW-1:0] pf;
		logic [FreqW-1:0] ff;
		logic [AmpW-1:0]  amp;
		logic             last;
		logic             pitch_ok;
	} work_t;

endpackage

@@ design/si_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_front : item classifier
// Applies the peak limit, forms the two frequencies and flags usable peaks.
// ----------------------------------------------------------------------------
module si_front #(
	parameter int PEAK_LIMIT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [6:0]          max_peaks,
	input  logic [23:0]         bin_freq_hz,
	input  logic [23:0]         pitch_hz,
	input  logic                pitch_valid,
	input  logic [19:0]         peak_bin,
	input  logic [23:0]         peak_amp,
	input  logic                peak_present,
	input  logic                last_peak,
	output si_pkg::work_t       work
);
	localparam int LimW = $clog2(PEAK_LIMIT + 1) > 7 ? $clog2(PEAK_LIMIT + 1) : 7;
	localparam logic [LimW-1:0] LimC = LimW'(PEAK_LIMIT);

	logic [6:0]      seen_q;
	logic [LimW-1:0] mp_ext, limit;
	logic            counted, pitch_ok;
	logic [43:0]     ff;

	assign mp_ext   = LimW'(max_peaks);
	assign limit    = (mp_ext < LimC) ? mp_ext : LimC;
	assign counted  = peak_present && (LimW'(seen_q) < limit);
	assign pitch_ok = pitch_valid && (pitch_hz != 24'd0);
	assign ff       = 44'(peak_bin) * 44'(bin_freq_hz);

	// peaks counted this frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (take) begin
			if (last_peak) seen_q <= '0;
			else if (counted && seen_q != 7'h7F) seen_q <= seen_q + 7'd1;
		end
	end

	always_comb begin
		work.use_peak = counted && pitch_ok && (ff != 44'd0);
		work.pf       = {8'd0, pitch_hz, 12'd0};
		work.ff       = ff;
		work.amp      = peak_amp;
		work.last     = last_peak;
		work.pitch_ok = pitch_ok;
	end
endmodule

@@ design/si_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_fifo : two-entry work queue
// Decouples the classifier from the arithmetic back end.
// ----------------------------------------------------------------------------
module si_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  si_pkg::work_t wdata,
	output logic          full,
	input  logic          rd,
	output si_pkg::work_t rdata,
	output logic          empty
);
	si_pkg::work_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !full && !(rd && !empty)) |=> !empty)
		else $error("write lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd) |=> full)
		else $error("full dropped without read");
endmodule

@@ design/si_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_back : divergence and frame mean unit
// One shared restoring divider, one quotient bit per cycle, does the modulo,
// the Q1.16 divergence and the final weighted mean.
// ----------------------------------------------------------------------------
module si_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wvalid,
	input  si_pkg::work_t wdata,
	output logic          wtake,
	output logic          rvalid,
	output logic [16:0]   inharmonicity,
	output logic          no_value,
	input  logic          rtake
);
	typedef enum logic [2:0] {
		S_IDLE, S_MOD, S_DIV, S_MAC, S_MEAN, S_OUT
	} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [47:0] num_q;      // dividend shifting out, quotient shifting in
	logic [43:0] rem_q;      // partial remainder
	logic [43:0] den_q;
	logic [23:0] amp_q;
	logic        last_q, pok_q;
	logic [47:0] wsum_q;
	logic [30:0] asum_q;
	logic [16:0] res_q;
	logic        nov_q;

	logic [44:0] trial;
	logic        ge;
	logic [43:0] rem_nx;
	logic [47:0] num_nx;
	logic [43:0] nfold;
	logic [40:0] prod;
	logic [47:0] wsum_nx;
	logic [30:0] asum_nx;

	// one restoring step
	assign trial  = {rem_q, num_q[47]};
	assign ge     = trial >= {1'b0, den_q};
	assign rem_nx = ge ? 44'(trial - {1'b0, den_q}) : trial[43:0];
	assign num_nx = {num_q[46:0], ge};

	// fold remainder to at most half the divisor
	assign nfold = ({rem_nx, 1'b0} > {1'b0, den_q}) ? den_q - rem_nx : rem_nx;

	// accumulate amp * d, 24 x 17 bits
	assign prod    = 41'(amp_q) * 41'(num_q[16:0]);
	assign wsum_nx = wsum_q + {7'd0, prod};
	assign asum_nx = asum_q + {7'd0, amp_q};

	assign wtake         = (state_q == S_IDLE) && wvalid;
	assign rvalid        = state_q == S_OUT;
	assign inharmonicity = res_q;
	assign no_value      = nov_q;

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			amp_q   <= '0;
			last_q  <= 1'b0;
			pok_q   <= 1'b0;
			wsum_q  <= '0;
			asum_q  <= '0;
			res_q   <= '0;
			nov_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (wvalid) begin
						last_q <= wdata.last;
						pok_q  <= wdata.pitch_ok;
						amp_q  <= wdata.amp;
						rem_q  <= '0;
						if (wdata.use_peak) begin
							// hi mod lo over the 44 frequency bits
							if (wdata.pf > wdata.ff) begin
								num_q <= {wdata.pf, 4'd0};
								den_q <= wdata.ff;
							end else begin
								num_q <= {wdata.ff, 4'd0};
								den_q <= wdata.pf;
							end
							cnt_q   <= 6'd44;
							state_q <= S_MOD;
						end else if (wdata.last) begin
							num_q   <= wsum_q;
							den_q   <= {13'd0, asum_q};
							cnt_q   <= 6'd48;
							state_q <= S_MEAN;
						end
					end
				end
				S_MOD: begin
					if (cnt_q == 6'd1) begin
						// n * 2^17 / lo: n preloaded, 17 zero bits give d
						rem_q   <= nfold;
						num_q   <= '0;
						cnt_q   <= 6'd17;
						state_q <= S_DIV;
					end else begin
						rem_q <= rem_nx;
						num_q <= num_nx;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_DIV: begin
					rem_q <= rem_nx;
					num_q <= num_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= S_MAC;
				end
				S_MAC: begin
					wsum_q <= wsum_nx;
					asum_q <= asum_nx;
					if (last_q) begin
						num_q   <= wsum_nx;
						den_q   <= {13'd0, asum_nx};
						rem_q   <= '0;
						cnt_q   <= 6'd48;
						state_q <= S_MEAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MEAN: begin
					rem_q <= rem_nx;
					num_q <= num_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						nov_q <= !pok_q || (asum_q == 31'd0);
						if (!pok_q || asum_q == 31'd0) res_q <= '0;
						else if (num_nx > 48'(si_pkg::Q_ONE)) res_q <= si_pkg::Q_ONE;
						else res_q <= num_nx[16:0];
						wsum_q  <= '0;
						asum_q  <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rtake) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) rvalid |-> !wtake)
		else $error("item taken while result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rvalid && !rtake) |=> (rvalid && $stable(inharmonicity)))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		rvalid |-> (inharmonicity <= si_pkg::Q_ONE))
		else $error("mean above one");
endmodule

@@ design/spectral_inharmonicity_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_inharmonicity_core : amplitude-weighted harmonic divergence
// Accepts spectral peaks of a frame and gives one weighted mean per frame.
// ----------------------------------------------------------------------------
// Usage: write max_peaks (index 0) and bin_freq_hz (index 1) through wr_en /
// wr_index / wr_data while idle. Push one peak per transaction while full is
// low; the front end classifies it at once and queues it (two entries).
// The back end runs one shared bit-serial divider and takes a new item only
// while idle: a usable peak is taken, then runs the modulo, the divergence
// and the accumulate step in turn; other items are only taken. A last item
// also runs the final mean, after which the result shows while empty is low.
// While a result waits to be popped the back end takes nothing more; the
// queue keeps accepting until it holds two transactions, then full rises.
// Reset clears sums, counters, queue and loads the register defaults.
// ----------------------------------------------------------------------------
module spectral_inharmonicity_core #(
	parameter int PEAK_LIMIT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [23:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic [23:0] pitch_hz,
	input  logic        pitch_valid,
	input  logic [19:0] peak_bin,
	input  logic [23:0] peak_amp,
	input  logic        peak_present,
	input  logic        last_peak,
	output logic        empty,
	input  logic        pop,
	output logic [16:0] inharmonicity,
	output logic        no_value
);
	logic [6:0]    max_peaks_q;
	logic [23:0]   bin_freq_q;
	si_pkg::work_t fw, qw;
	logic          qempty, btake, rvalid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_peaks_q <= 7'd10;
			bin_freq_q  <= 24'd44100;
		end else if (wr_en) begin
			if (wr_index == si_pkg::REG_MAX_PEAKS) max_peaks_q <= wr_data[6:0];
			else bin_freq_q <= wr_data;
		end
	end

	si_front #(.PEAK_LIMIT(PEAK_LIMIT)) u_front (
		.clk, .arst_n, .take(push && !full), .max_peaks(max_peaks_q),
		.bin_freq_hz(bin_freq_q), .pitch_hz, .pitch_valid, .peak_bin, .peak_amp,
		.peak_present, .last_peak, .work(fw)
	);

	si_fifo u_fifo (
		.clk, .arst_n, .wr(push), .wdata(fw), .full, .rd(btake), .rdata(qw),
		.empty(qempty)
	);

	si_back u_back (
		.clk, .arst_n, .wvalid(!qempty), .wdata(qw), .wtake(btake), .rvalid,
		.inharmonicity, .no_value, .rtake(pop)
	);

	assign empty = !rvalid;
endmodule
